/* rtl/core/i2cbb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the I2C bit-bang master.
// No dependencies; imported by every module of the block.
package i2cbb_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_SEND  = 2'd1;
    localparam logic [1:0] CMD_GET   = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] command;
        logic [6:0] slave_address;
        logic       read_not_write;
        logic [7:0] tx_byte;
        logic       master_nack;
        logic       sda_in;
    } i2cbb_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       slave_ack;
    } i2cbb_res_t;

endpackage

/* rtl/core/i2cbb_seq.sv */
`timescale 1ns / 1ps
// Bus sequencer: phase state, tick counter, shift register and pin levels.
// Advances one tick per step; depends on i2cbb_pkg.
module i2cbb_seq
    import i2cbb_pkg::*;
#(
    parameter int DELAY_COUNTER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  i2cbb_item_t item,
    input  logic [15:0] half_period,
    output i2cbb_res_t  res
);

    localparam int CW = DELAY_COUNTER_WIDTH;
    localparam int LW = ((CW > 16) ? CW : 16) + 1;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ST_A   = 4'd1;
    localparam logic [3:0] PH_ST_B   = 4'd2;
    localparam logic [3:0] PH_ST_C   = 4'd3;
    localparam logic [3:0] PH_BIT_HI = 4'd4;
    localparam logic [3:0] PH_BIT_LO = 4'd5;
    localparam logic [3:0] PH_ACK_HI = 4'd6;
    localparam logic [3:0] PH_ACK_LO = 4'd7;
    localparam logic [3:0] PH_RD_HI  = 4'd8;
    localparam logic [3:0] PH_RD_LO  = 4'd9;
    localparam logic [3:0] PH_MA_HI  = 4'd10;
    localparam logic [3:0] PH_MA_LO  = 4'd11;
    localparam logic [3:0] PH_SP_A   = 4'd12;
    localparam logic [3:0] PH_SP_B   = 4'd13;
    localparam logic [3:0] PH_SP_C   = 4'd14;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    logic [3:0]    phase_reg, phase_next;
    logic [3:0]    bitc_reg, bitc_next;
    logic [7:0]    shift_reg, shift_next;
    logic [CW-1:0] tick_reg, tick_next;
    logic          scl_reg, scl_next;
    logic          sda_reg, sda_next;
    logic          en_reg, en_next;
    logic [7:0]    rxb_reg, rxb_next;
    logic          ack_reg, ack_next;
    logic          done;

    logic [LW-1:0] half_ext;
    logic [LW-1:0] cap;
    logic [LW-1:0] eff_len;
    logic [LW-1:0] tick_inc;
    logic          phase_end;
    logic [3:0]    bitc_inc;

    // Zero counts as one tick; lengths beyond the counter range saturate.
    assign half_ext  = LW'(half_period);
    assign cap       = LW'(1) << CW;
    assign eff_len   = (half_period == 16'd0) ? LW'(1) :
                       ((half_ext > cap) ? cap : half_ext);
    assign tick_inc  = LW'(tick_reg) + LW'(1);
    assign phase_end = (tick_inc >= eff_len);
    assign bitc_inc  = bitc_reg + 4'd1;

    always_comb
    begin
        phase_next = phase_reg;
        bitc_next  = bitc_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        en_next    = en_reg;
        rxb_next   = rxb_reg;
        ack_next   = ack_reg;
        done       = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd_valid)
            begin
                tick_next = '0;
                bitc_next = '0;
                unique case (item.command)
                    CMD_START:
                    begin
                        shift_next = {item.slave_address, item.read_not_write};
                        en_next    = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = PH_ST_A;
                    end
                    CMD_SEND:
                    begin
                        shift_next = item.tx_byte;
                        en_next    = 1'b1;
                        sda_next   = item.tx_byte[7];
                        scl_next   = 1'b1;
                        phase_next = PH_BIT_HI;
                    end
                    CMD_GET:
                    begin
                        shift_next = '0;
                        en_next    = 1'b0;
                        sda_next   = item.master_nack;
                        scl_next   = 1'b1;
                        phase_next = PH_RD_HI;
                    end
                    CMD_STOP:
                    begin
                        en_next    = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PH_SP_A;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (phase_end)
        begin
            tick_next = '0;
            unique case (phase_reg)
                PH_ST_A:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST_B;
                end
                PH_ST_B:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_ST_C;
                end
                PH_ST_C:
                begin
                    bitc_next  = '0;
                    en_next    = 1'b1;
                    sda_next   = shift_reg[7];
                    scl_next   = 1'b1;
                    phase_next = PH_BIT_HI;
                end
                PH_BIT_HI:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_BIT_LO;
                end
                PH_BIT_LO:
                begin
                    bitc_next  = bitc_inc;
                    shift_next = {shift_reg[6:0], 1'b0};
                    scl_next   = 1'b1;
                    if (bitc_inc >= BITS_PER_BYTE)
                    begin
                        // release SDA for the slave ACK slot
                        en_next    = 1'b0;
                        phase_next = PH_ACK_HI;
                    end
                    else
                    begin
                        sda_next   = shift_reg[6];
                        phase_next = PH_BIT_HI;
                    end
                end
                PH_ACK_HI:
                begin
                    ack_next   = item.sda_in;
                    scl_next   = 1'b0;
                    phase_next = PH_ACK_LO;
                end
                PH_ACK_LO:
                begin
                    en_next    = 1'b1;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                PH_RD_HI:
                begin
                    shift_next = {shift_reg[6:0], item.sda_in};
                    scl_next   = 1'b0;
                    phase_next = PH_RD_LO;
                end
                PH_RD_LO:
                begin
                    bitc_next = bitc_inc;
                    scl_next  = 1'b1;
                    if (bitc_inc >= BITS_PER_BYTE)
                    begin
                        rxb_next   = shift_reg;
                        en_next    = 1'b1;
                        phase_next = PH_MA_HI;
                    end
                    else
                    begin
                        phase_next = PH_RD_HI;
                    end
                end
                PH_MA_HI:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_MA_LO;
                end
                PH_SP_A:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_SP_B;
                end
                PH_SP_B:
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_SP_C;
                end
                default:
                begin
                    // end of master ACK, end of stop, and unused codes
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else
        begin
            tick_next = tick_inc[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bitc_reg  <= '0;
            shift_reg <= '0;
            tick_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            en_reg    <= 1'b1;
            rxb_reg   <= '0;
            ack_reg   <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bitc_reg  <= bitc_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            en_reg    <= en_next;
            rxb_reg   <= rxb_next;
            ack_reg   <= ack_next;
        end
    end

    assign res.scl_out   = scl_next;
    assign res.sda_out   = sda_next;
    assign res.sda_drive = en_next;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.done_res  = done;
    assign res.rx_byte   = rxb_next;
    assign res.slave_ack = ack_next;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |-> !res.busy_res)
        else $error("done reported while still busy");

    a_release_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !en_reg |-> (phase_reg == PH_ACK_HI || phase_reg == PH_ACK_LO ||
                     phase_reg == PH_RD_HI || phase_reg == PH_RD_LO))
        else $error("SDA released outside an ACK or read slot");

    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        bitc_reg <= BITS_PER_BYTE)
        else $error("bit counter ran past one byte");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IDLE && !item.cmd_valid) |=> (phase_reg == PH_IDLE))
        else $error("left idle without a command");

endmodule

/* rtl/core/i2cbb_out_reg.sv */
`timescale 1ns / 1ps
// Result register for the I2C bit-bang master output channel.
// Holds one result under stall; depends on i2cbb_pkg.
module i2cbb_out_reg
    import i2cbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  i2cbb_res_t res,
    input  logic       out_stall,
    output logic       out_valid,
    output i2cbb_res_t res_q
);

    logic       vld_reg, vld_next;
    i2cbb_res_t data_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
            vld_next = 1'b1;
        else if (!out_stall)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_valid = vld_reg;
    assign res_q     = data_reg;

endmodule

/* rtl/core/i2c_bit_bang_master.sv */
`timescale 1ns / 1ps
// Top level of the tick-driven I2C master: input register, sequencer, result register.
// Depends on i2cbb_pkg, i2cbb_seq and i2cbb_out_reg.
//
//  channel | handshake            | carries
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | cmd_valid, command, slave_address,
//          |                      | read_not_write, tx_byte, master_nack, sda_in
//  out     | out_valid/out_stall  | scl_out, sda_out, sda_drive, busy_res, done_res,
//          |                      | rx_byte, slave_ack
//  cfg     | cfg_valid/cfg_ready  | cfg_data = half_period_ticks
//
// One tick per clock unless the output stalls: a tick enters the input register,
// and the sequencer steps on it as its result is loaded into the output register.
// Full rate is set by the sequencer step, whose next-state logic is combinational.
// Reset puts the bus idle (SCL, SDA high, driven) and the half period at 250 ticks.
// A stalled output holds its result; the input stalls only while both stages are full.
module i2c_bit_bang_master
    import i2cbb_pkg::*;
#(
    parameter int DELAY_COUNTER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd_valid,
    input  logic [1:0]  command,
    input  logic [6:0]  slave_address,
    input  logic        read_not_write,
    input  logic [7:0]  tx_byte,
    input  logic        master_nack,
    input  logic        sda_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_out,
    output logic        sda_out,
    output logic        sda_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        slave_ack,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        in_vld_reg, in_vld_next;
    i2cbb_item_t item_reg;
    logic [15:0] half_reg;
    logic        load;
    logic        accept;
    i2cbb_res_t  res;
    i2cbb_res_t  res_q;
    logic        out_vld;

    assign load     = in_vld_reg && (!out_vld || !out_stall);
    assign in_stall = in_vld_reg && !load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (load)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            half_reg   <= HALF_PERIOD_RESET;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_valid)
                half_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd_valid      <= cmd_valid;
            item_reg.command        <= command;
            item_reg.slave_address  <= slave_address;
            item_reg.read_not_write <= read_not_write;
            item_reg.tx_byte        <= tx_byte;
            item_reg.master_nack    <= master_nack;
            item_reg.sda_in         <= sda_in;
        end
    end

    assign cfg_ready = 1'b1;

    i2cbb_seq #(
        .DELAY_COUNTER_WIDTH (DELAY_COUNTER_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (load),
        .item        (item_reg),
        .half_period (half_reg),
        .res         (res)
    );

    i2cbb_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_vld),
        .res_q     (res_q)
    );

    assign out_valid = out_vld;
    assign scl_out   = res_q.scl_out;
    assign sda_out   = res_q.sda_out;
    assign sda_drive = res_q.sda_drive;
    assign busy_res  = res_q.busy_res;
    assign done_res  = res_q.done_res;
    assign rx_byte   = res_q.rx_byte;
    assign slave_ack = res_q.slave_ack;

endmodule

/* sim/i2c_bit_bang_master_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for i2c_bit_bang_master: drives tick items, predicts each
// result with a cycle-true model of the bus sequencer and checks every output field.
// Depends on i2cbb_pkg and the i2c_bit_bang_master RTL.
module i2c_bit_bang_master_tb;
    import i2cbb_pkg::*;

    typedef enum logic [3:0] {
        BUS_IDLE, ST_A, ST_B, ST_C, BIT_HI, BIT_LO, ACK_HI, ACK_LO,
        RD_HI, RD_LO, MA_HI, MA_LO, SP_A, SP_B, SP_C
    } bus_phase_t;

    localparam int PIN_LOW  = 0;
    localparam int PIN_HIGH = 1;
    localparam int PIN_RAND = 2;

    // Tracks the bus sequencer tick by tick and holds the results still owed by the block.
    class i2c_tick_board_t;
        bus_phase_t  phase;
        logic [1:0]  cur_cmd;
        logic [3:0]  bit_cnt;
        logic [7:0]  shreg;
        logic [15:0] tick_cnt;
        logic        scl;
        logic        sda;
        logic        sda_en;
        logic [7:0]  rx_q;
        logic        ack;
        logic [15:0] half_period;
        i2cbb_res_t  expected_q[$];
        int          errors;

        function new();
            half_period = HALF_PERIOD_RESET;
            phase       = BUS_IDLE;
            cur_cmd     = CMD_START;
            bit_cnt     = '0;
            shreg       = '0;
            tick_cnt    = '0;
            scl         = 1'b1;
            sda         = 1'b1;
            sda_en      = 1'b1;
            rx_q        = '0;
            ack         = 1'b1;
            errors      = 0;
        endfunction

        function bit bus_idle();
            return phase == BUS_IDLE;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void load_byte(logic [7:0] b);
            shreg   = b;
            bit_cnt = '0;
            sda_en  = 1'b1;
            sda     = b[7];
            scl     = 1'b1;
            phase   = BIT_HI;
        endfunction

        // Leave the current bus phase; return 1 when the command is complete.
        function bit leave_phase(logic pin);
            case (phase)
                ST_A:
                begin
                    sda   = 1'b0;
                    phase = ST_B;
                end
                ST_B:
                begin
                    scl   = 1'b0;
                    phase = ST_C;
                end
                ST_C: load_byte(shreg);
                BIT_HI:
                begin
                    scl   = 1'b0;
                    phase = BIT_LO;
                end
                BIT_LO:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    shreg   = shreg << 1;
                    scl     = 1'b1;
                    if (bit_cnt >= 4'd8)
                    begin
                        sda_en = 1'b0;
                        phase  = ACK_HI;
                    end
                    else
                    begin
                        sda   = shreg[7];
                        phase = BIT_HI;
                    end
                end
                ACK_HI:
                begin
                    ack   = pin;
                    scl   = 1'b0;
                    phase = ACK_LO;
                end
                ACK_LO:
                begin
                    sda_en = 1'b1;
                    return 1'b1;
                end
                RD_HI:
                begin
                    shreg = {shreg[6:0], pin};
                    scl   = 1'b0;
                    phase = RD_LO;
                end
                RD_LO:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    scl     = 1'b1;
                    if (bit_cnt >= 4'd8)
                    begin
                        rx_q   = shreg;
                        sda_en = 1'b1;
                        phase  = MA_HI;
                    end
                    else
                    begin
                        phase = RD_HI;
                    end
                end
                MA_HI:
                begin
                    scl   = 1'b0;
                    phase = MA_LO;
                end
                MA_LO: return 1'b1;
                SP_A:
                begin
                    scl   = 1'b1;
                    phase = SP_B;
                end
                SP_B:
                begin
                    sda   = 1'b1;
                    phase = SP_C;
                end
                default: return 1'b1;
            endcase
            return 1'b0;
        endfunction

        function void note_tick(i2cbb_item_t it);
            logic       done;
            logic [16:0] span;
            i2cbb_res_t res;
            done = 1'b0;
            span = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
            if (phase == BUS_IDLE)
            begin
                if (it.cmd_valid)
                begin
                    cur_cmd  = it.command;
                    tick_cnt = '0;
                    bit_cnt  = '0;
                    case (it.command)
                        CMD_START:
                        begin
                            shreg  = {it.slave_address, it.read_not_write};
                            sda_en = 1'b1;
                            sda    = 1'b1;
                            scl    = 1'b1;
                            phase  = ST_A;
                        end
                        CMD_SEND: load_byte(it.tx_byte);
                        CMD_GET:
                        begin
                            shreg  = '0;
                            sda_en = 1'b0;
                            sda    = it.master_nack;
                            scl    = 1'b1;
                            phase  = RD_HI;
                        end
                        default:
                        begin
                            sda_en = 1'b1;
                            sda    = 1'b0;
                            phase  = SP_A;
                        end
                    endcase
                end
            end
            else if ({1'b0, tick_cnt} + 17'd1 >= span)
            begin
                tick_cnt = '0;
                if (leave_phase(it.sda_in))
                begin
                    phase = BUS_IDLE;
                    done  = 1'b1;
                end
            end
            else
            begin
                tick_cnt = tick_cnt + 16'd1;
            end
            res.scl_out   = scl;
            res.sda_out   = sda;
            res.sda_drive = sda_en;
            res.busy_res  = (phase != BUS_IDLE);
            res.done_res  = done;
            res.rx_byte   = rx_q;
            res.slave_ack = ack;
            expected_q.push_back(res);
        endfunction

        task complain(string msg);
            if (errors < 100)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(i2cbb_res_t got);
            i2cbb_res_t exp;
            if (expected_q.size() == 0)
            begin
                complain("result arrived with no tick outstanding");
                return;
            end
            exp = expected_q.pop_front();
            if (got.scl_out !== exp.scl_out)
                complain($sformatf("scl_out got %b exp %b", got.scl_out, exp.scl_out));
            if (got.sda_out !== exp.sda_out)
                complain($sformatf("sda_out got %b exp %b", got.sda_out, exp.sda_out));
            if (got.sda_drive !== exp.sda_drive)
                complain($sformatf("sda_drive got %b exp %b", got.sda_drive, exp.sda_drive));
            if (got.busy_res !== exp.busy_res)
                complain($sformatf("busy_res got %b exp %b", got.busy_res, exp.busy_res));
            if (got.done_res !== exp.done_res)
                complain($sformatf("done_res got %b exp %b", got.done_res, exp.done_res));
            if (got.rx_byte !== exp.rx_byte)
                complain($sformatf("rx_byte got %h exp %h", got.rx_byte, exp.rx_byte));
            if (got.slave_ack !== exp.slave_ack)
                complain($sformatf("slave_ack got %b exp %b", got.slave_ack, exp.slave_ack));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd_valid = 1'b0;
    logic [1:0]  command = CMD_START;
    logic [6:0]  slave_address = '0;
    logic        read_not_write = 1'b0;
    logic [7:0]  tx_byte = '0;
    logic        master_nack = 1'b0;
    logic        sda_in = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        scl_out;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        slave_ack;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    i2c_tick_board_t board = new();

    bit sender_gaps    = 1'b1;
    bit sink_stalls    = 1'b1;
    bit long_hold_req  = 1'b0;
    bit in_txn         = 1'b0;
    int txn_left       = 0;

    i2c_bit_bang_master i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd_valid      (cmd_valid),
        .command        (command),
        .slave_address  (slave_address),
        .read_not_write (read_not_write),
        .tx_byte        (tx_byte),
        .master_nack    (master_nack),
        .sda_in         (sda_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scl_out        (scl_out),
        .sda_out        (sda_out),
        .sda_drive      (sda_drive),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .rx_byte        (rx_byte),
        .slave_ack      (slave_ack),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: check each transfer, stall in random bursts or one long hold.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result({scl_out, sda_out, sda_drive, busy_res, done_res,
                                    rx_byte, slave_ack});
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 60;
                out_stall <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one tick and wait for its transfer; the predictor steps on acceptance.
    task automatic put_tick(input i2cbb_item_t it);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd_valid      <= it.cmd_valid;
        command        <= it.command;
        slave_address  <= it.slave_address;
        read_not_write <= it.read_not_write;
        tx_byte        <= it.tx_byte;
        master_nack    <= it.master_nack;
        sda_in         <= it.sda_in;
        do @(posedge clk); while (in_stall);
        board.note_tick(it);
    endtask

    function automatic i2cbb_item_t random_tick();
        logic [20:0] raw;
        raw = 21'($urandom);
        return raw;
    endfunction

    function automatic logic pick_pin(input int pin_mode);
        if (pin_mode == PIN_RAND)
            return 1'($urandom_range(0, 1));
        return (pin_mode == PIN_HIGH);
    endfunction

    // Tick until the bus command completes; commands offered meanwhile must be dropped.
    task automatic idle_out(input int pin_mode);
        i2cbb_item_t it;
        while (!board.bus_idle())
        begin
            it = random_tick();
            it.sda_in = pick_pin(pin_mode);
            put_tick(it);
        end
    endtask

    task automatic run_command(input logic [1:0] cmd, input logic [6:0] addr,
                               input logic rnw, input logic [7:0] txb,
                               input logic nack, input int pin_mode);
        i2cbb_item_t it;
        it.cmd_valid      = 1'b1;
        it.command        = cmd;
        it.slave_address  = addr;
        it.read_not_write = rnw;
        it.tx_byte        = txb;
        it.master_nack    = nack;
        it.sda_in         = pick_pin(pin_mode);
        put_tick(it);
        idle_out(pin_mode);
    endtask

    // Mostly well-formed transactions: start, a few bytes, stop.
    function automatic logic [1:0] pick_command();
        if ($urandom_range(0, 9) == 0)
            return 2'($urandom_range(0, 3));
        if (!in_txn)
        begin
            in_txn   = 1'b1;
            txn_left = $urandom_range(1, 3);
            return CMD_START;
        end
        if (txn_left > 0)
        begin
            txn_left--;
            return $urandom_range(0, 1) ? CMD_SEND : CMD_GET;
        end
        in_txn = 1'b0;
        return CMD_STOP;
    endfunction

    task automatic run_bus_traffic(input int n_ticks);
        i2cbb_item_t it;
        for (int i = 0; i < n_ticks; i++)
        begin
            it = random_tick();
            if (board.bus_idle())
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    it.cmd_valid = 1'b1;
                    it.command   = pick_command();
                end
            end
            else
            begin
                it.cmd_valid = ($urandom_range(0, 4) == 0);
            end
            put_tick(it);
        end
        idle_out(PIN_RAND);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_half_period(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.half_period = value;
    endtask

    initial
    begin
        i2cbb_item_t it;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset half period: quiet bus, then a start that is cut short by a rewrite.
        for (int i = 0; i < 3; i++)
        begin
            it = '0;
            it.sda_in = i[0];
            put_tick(it);
        end
        it = '0;
        it.cmd_valid      = 1'b1;
        it.command        = CMD_START;
        it.slave_address  = 7'h7F;
        it.read_not_write = 1'b1;
        put_tick(it);
        for (int i = 0; i < 5; i++)
            put_tick(random_tick());
        settle();

        // Zero half period acts as one tick; finish the start, then each command.
        write_half_period(16'd0);
        idle_out(PIN_RAND);
        run_command(CMD_SEND, 7'h00, 1'b0, 8'hFF, 1'b0, PIN_LOW);
        run_command(CMD_GET,  7'h00, 1'b0, 8'h00, 1'b1, PIN_HIGH);
        run_command(CMD_GET,  7'h7F, 1'b1, 8'hFF, 1'b0, PIN_LOW);
        run_command(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, PIN_RAND);
        run_command(CMD_SEND, 7'h7F, 1'b1, 8'h00, 1'b1, PIN_HIGH);
        run_command(CMD_GET,  7'h55, 1'b0, 8'hA5, 1'b1, PIN_RAND);
        run_command(CMD_STOP, 7'h2A, 1'b1, 8'h5A, 1'b1, PIN_RAND);
        run_command(CMD_START, 7'h00, 1'b0, 8'hFF, 1'b1, PIN_RAND);
        run_command(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, PIN_RAND);
        settle();

        write_half_period(16'd1);
        run_bus_traffic(60);
        settle();

        // Hold the result side long enough to back up the input.
        write_half_period(16'd2);
        sender_gaps = 1'b0;
        long_hold_req = 1'b1;
        run_bus_traffic(60);
        sender_gaps = 1'b1;
        settle();

        write_half_period(16'd3);
        sink_stalls = 1'b0;
        run_bus_traffic(60);
        sink_stalls = 1'b1;
        settle();

        write_half_period(16'd0);
        run_bus_traffic(60);
        settle();

        write_half_period(16'd7);
        run_bus_traffic(60);
        settle();

        // Longest half period: the counter runs but no phase ends; shorten it mid-command.
        write_half_period(16'hFFFF);
        it = '0;
        it.cmd_valid = 1'b1;
        it.command   = CMD_SEND;
        it.tx_byte   = 8'h96;
        put_tick(it);
        for (int i = 0; i < 40; i++)
            put_tick(random_tick());
        settle();
        write_half_period(16'd1);
        idle_out(PIN_RAND);
        settle();
        write_half_period(16'hFFFF);
        it = random_tick();
        it.cmd_valid = 1'b1;
        it.command   = CMD_START;
        put_tick(it);
        for (int i = 0; i < 40; i++)
            put_tick(random_tick());
        settle();
        write_half_period(16'd2);
        idle_out(PIN_RAND);
        settle();

        // Full rate to the end.
        write_half_period(16'd1);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        run_bus_traffic(60);
        settle();
        repeat (8) @(posedge clk);

        if (board.pending() != 0)
            board.complain($sformatf("%0d results never arrived", board.pending()));
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
